@@ hdl/alsf_pkg.sv @@
package alsf_pkg;

  localparam int ARRAY_ROWS_DEF = 16;

  localparam int PHASE_W = 3;
  localparam int SW_W    = 2;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REGLOAD   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TRANSLOAD = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FIRSTLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REUSELOAD = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DOUT      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REUSE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_KERNEL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_TIMES     = 2'd3;

  // transpose and reuse codes used by the switch logic
  localparam logic [1:0] TR_B_ONLY  = 2'd1;
  localparam logic [1:0] TR_A_AND_B = 2'd2;
  localparam logic [1:0] REUSE_SPECIAL = 2'd2;

  localparam logic [3:0] CONV_REG_MIN = 4'd3;

  localparam logic [SW_W-1:0] SW_NONE  = 2'd0;
  localparam logic [SW_W-1:0] SW_REUSE = 2'd1;
  localparam logic [SW_W-1:0] SW_BOTH  = 2'd3;

  typedef struct packed {
    logic [1:0] reuse_mode;
    logic [1:0] transpose_mode;
    logic [3:0] conv_kernel;
    logic [5:0] flow_times;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic load_done;
    logic execute_finished;
    logic last_instruction;
    logic register_file_clear;
    logic update_finished;
    logic write_finished;
    logic last_flow_clear;
  } flags_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [SW_W-1:0]    operand_switch;
    logic [COUNT_W-1:0] flow_count;
    logic               last_flow_mark;
    logic               flow_end;
    logic               crossbar_done;
  } result_t;

endpackage

@@ hdl/array_load_scheduler_fsm.sv @@
// A result beat passes the input register (stage 1), then the output register.
// Throughput: one beat per cycle unless out_stall holds the output; the state advances
// once per beat in the core, between the input register and the output register.
// Reset (rst, synchronous): phase idle, all counters, flags, the switch and the
// configuration registers go to zero; both pipeline registers empty.
module array_load_scheduler_fsm #(
  parameter int ARRAY_ROWS = alsf_pkg::ARRAY_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             start_req,
  input  logic                             load_done,
  input  logic                             execute_finished,
  input  logic                             last_instruction,
  input  logic                             register_file_clear,
  input  logic                             update_finished,
  input  logic                             write_finished,
  input  logic                             last_flow_clear,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [alsf_pkg::PHASE_W-1:0]    phase,
  output logic [alsf_pkg::SW_W-1:0]       operand_switch,
  output logic [alsf_pkg::COUNT_W-1:0]    flow_count,
  output logic                             last_flow_mark,
  output logic                             flow_end,
  output logic                             crossbar_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [alsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alsf_pkg::CFG_DATA_W-1:0] cfg_data
);

  alsf_pkg::cfg_t    cfg;
  alsf_pkg::flags_t  in_flags;
  alsf_pkg::flags_t  s1_flags;
  alsf_pkg::result_t core_res;
  alsf_pkg::result_t out_res;
  logic              s1_valid, s1_valid_next;
  logic              out_valid_next;
  logic              accept, advance;

  alsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_flags = '{start_req:           start_req,
                      load_done:           load_done,
                      execute_finished:    execute_finished,
                      last_instruction:    last_instruction,
                      register_file_clear: register_file_clear,
                      update_finished:     update_finished,
                      write_finished:      write_finished,
                      last_flow_clear:     last_flow_clear};

  // stage 1 moves into the output register whenever that register frees up
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) s1_valid_next = 1'b1;
    else if (advance) s1_valid_next = 1'b0;

    out_valid_next = out_valid;
    if (advance) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_flags <= in_flags;
    if (advance) out_res <= core_res;
  end

  alsf_core #(
    .ARRAY_ROWS (ARRAY_ROWS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .cfg   (cfg),
    .flags (s1_flags),
    .res   (core_res)
  );

  assign phase          = out_res.phase;
  assign operand_switch = out_res.operand_switch;
  assign flow_count     = out_res.flow_count;
  assign last_flow_mark = out_res.last_flow_mark;
  assign flow_end       = out_res.flow_end;
  assign crossbar_done  = out_res.crossbar_done;

endmodule

@@ hdl/alsf_cfg_regs.sv @@
module alsf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [alsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alsf_pkg::CFG_DATA_W-1:0] cfg_data,
  output alsf_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        alsf_pkg::REG_REUSE_MODE:     cfg.reuse_mode     <= cfg_data[1:0];
        alsf_pkg::REG_TRANSPOSE_MODE: cfg.transpose_mode <= cfg_data[1:0];
        alsf_pkg::REG_CONV_KERNEL:    cfg.conv_kernel    <= cfg_data[3:0];
        alsf_pkg::REG_FLOW_TIMES:     cfg.flow_times     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/alsf_core.sv @@
module alsf_core #(
  parameter int ARRAY_ROWS = alsf_pkg::ARRAY_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  alsf_pkg::cfg_t    cfg,
  input  alsf_pkg::flags_t  flags,
  output alsf_pkg::result_t res
);

  localparam int ROW_W = $clog2(ARRAY_ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ARRAY_ROWS - 1);

  logic [alsf_pkg::PHASE_W-1:0] phase, phase_next;
  logic                         instr_valid;
  logic                         load_done_delayed;
  logic                         conv_reuse_flag;
  logic                         crossbar_done;
  logic [alsf_pkg::COUNT_W-1:0] flow_counter, flow_counter_next;
  logic                         last_flow, last_flow_next;
  logic [ROW_W-1:0]             row_counter, row_counter_next;
  logic [alsf_pkg::SW_W-1:0]    switch_sel, switch_sel_next;

  logic                         flow_end;
  logic                         reuse, transpose, execute, conv_mode;
  logic                         conv_big;
  logic [alsf_pkg::COUNT_W-1:0] target;
  logic                         counter_clear, row_last, reuse_exit;
  logic                         sw_bit;

  always_comb begin
    if (phase != alsf_pkg::PH_DOUT) begin
      flow_end = 1'b0;
    end else if (flags.last_instruction) begin
      flow_end = flags.register_file_clear;
    end else begin
      flow_end = flags.update_finished || flags.write_finished;
    end
  end

  assign reuse     = cfg.reuse_mode != 2'd0;
  assign transpose = cfg.transpose_mode != 2'd0;
  assign execute   = switch_sel[0] ^ switch_sel[1];
  assign conv_mode = reuse && execute;
  assign conv_big  = cfg.conv_kernel >= alsf_pkg::CONV_REG_MIN;

  // no reuse: 2*flow_times - 1, wrapping at 7 bits
  assign target = reuse ? {1'b0, cfg.flow_times}
                        : {cfg.flow_times, 1'b0} - 7'd1;

  assign counter_clear = (flow_counter == target) && flags.load_done;
  assign row_last      = row_counter == ROW_LAST;
  // a zero target is excluded: target-1 would wrap to 127
  assign reuse_exit    = (target != '0) && (flow_counter == target - 7'd1)
                         && flags.load_done && transpose;
  assign sw_bit        = ~cfg.transpose_mode[0];

  always_comb begin
    case (phase)
      alsf_pkg::PH_REGLOAD: begin
        if (transpose && flags.load_done) phase_next = alsf_pkg::PH_TRANSLOAD;
        else if (conv_reuse_flag && flags.load_done) phase_next = alsf_pkg::PH_REUSELOAD;
        else phase_next = alsf_pkg::PH_REGLOAD;
      end
      alsf_pkg::PH_TRANSLOAD: begin
        phase_next = (row_last || flags.load_done) ? alsf_pkg::PH_REUSELOAD
                                                   : alsf_pkg::PH_TRANSLOAD;
      end
      alsf_pkg::PH_FIRSTLOAD: begin
        if (flags.execute_finished) phase_next = alsf_pkg::PH_DOUT;
        else if (conv_mode && flags.load_done) phase_next = alsf_pkg::PH_REUSELOAD;
        else phase_next = alsf_pkg::PH_FIRSTLOAD;
      end
      alsf_pkg::PH_REUSELOAD: begin
        if (flags.execute_finished) phase_next = alsf_pkg::PH_DOUT;
        else if (reuse_exit) phase_next = alsf_pkg::PH_FIRSTLOAD;
        else phase_next = alsf_pkg::PH_REUSELOAD;
      end
      alsf_pkg::PH_DOUT: begin
        phase_next = flow_end ? alsf_pkg::PH_IDLE : alsf_pkg::PH_DOUT;
      end
      default: begin
        if (instr_valid && conv_big) phase_next = alsf_pkg::PH_REGLOAD;
        else if (instr_valid) phase_next = alsf_pkg::PH_FIRSTLOAD;
        else phase_next = alsf_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    row_counter_next = row_counter;
    if (flags.start_req) begin
      row_counter_next = '0;
    end else if (phase == alsf_pkg::PH_TRANSLOAD) begin
      row_counter_next = row_last ? '0 : row_counter + 1'b1;
    end

    flow_counter_next = flow_counter;
    if (flags.start_req || counter_clear) begin
      flow_counter_next = '0;
    end else if (flags.load_done) begin
      flow_counter_next = flow_counter + 1'b1;
    end

    last_flow_next = last_flow;
    if (flags.start_req || flags.last_flow_clear) begin
      last_flow_next = 1'b0;
    end else if (counter_clear) begin
      last_flow_next = 1'b1;
    end
  end

  always_comb begin
    switch_sel_next = switch_sel;
    case (phase)
      alsf_pkg::PH_FIRSTLOAD, alsf_pkg::PH_REGLOAD: begin
        if (load_done_delayed && !conv_mode) begin
          switch_sel_next = {switch_sel[1], ~switch_sel[0]};
        end
      end
      alsf_pkg::PH_TRANSLOAD: ;
      alsf_pkg::PH_REUSELOAD: begin
        if (conv_reuse_flag) begin
          switch_sel_next = alsf_pkg::SW_REUSE;
        end else if (!(cfg.transpose_mode == alsf_pkg::TR_B_ONLY ||
                       cfg.transpose_mode == cfg.reuse_mode)) begin
          switch_sel_next = {sw_bit, sw_bit ^ last_flow};
        end
      end
      alsf_pkg::PH_DOUT: begin
        if (flow_end) switch_sel_next = alsf_pkg::SW_NONE;
      end
      default: begin
        switch_sel_next = (cfg.transpose_mode == alsf_pkg::TR_A_AND_B ||
                           (cfg.transpose_mode == alsf_pkg::TR_B_ONLY &&
                            cfg.reuse_mode == alsf_pkg::REUSE_SPECIAL))
                          ? alsf_pkg::SW_BOTH : alsf_pkg::SW_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= alsf_pkg::PH_IDLE;
      instr_valid       <= 1'b0;
      load_done_delayed <= 1'b0;
      conv_reuse_flag   <= 1'b0;
      crossbar_done     <= 1'b0;
      flow_counter      <= '0;
      last_flow         <= 1'b0;
      row_counter       <= '0;
      switch_sel        <= '0;
    end else if (step) begin
      phase             <= phase_next;
      instr_valid       <= flags.start_req;
      load_done_delayed <= flags.load_done;
      conv_reuse_flag   <= conv_big;
      crossbar_done     <= flow_end;
      flow_counter      <= flow_counter_next;
      last_flow         <= last_flow_next;
      row_counter       <= row_counter_next;
      switch_sel        <= switch_sel_next;
    end
  end

  // outputs reflect the state before this beat's update
  always_comb begin
    res.phase          = phase;
    res.operand_switch = switch_sel;
    res.flow_count     = flow_counter;
    res.last_flow_mark = last_flow;
    res.flow_end       = flow_end;
    res.crossbar_done  = crossbar_done;
  end

endmodule

@@ tb/alsf_sched_checker.sv @@
`timescale 1ns / 100ps

module alsf_sched_checker #(
  parameter int ROWS = alsf_pkg::ARRAY_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  alsf_pkg::flags_t                 in_flags,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [alsf_pkg::PHASE_W-1:0]    phase,
  input  logic [alsf_pkg::SW_W-1:0]       operand_switch,
  input  logic [alsf_pkg::COUNT_W-1:0]    flow_count,
  input  logic                             last_flow_mark,
  input  logic                             flow_end,
  input  logic                             crossbar_done,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [alsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alsf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               errors,
  output int                               pending
);
  import alsf_pkg::*;

  cfg_t               cfg_q;
  logic [PHASE_W-1:0] ph_q;
  logic               started_q;
  logic               ld_dly_q;
  logic               conv_reuse_q;
  logic               xbar_q;
  logic               last_flow_q;
  logic [COUNT_W-1:0] flow_q;
  int                 row_q;
  logic [SW_W-1:0]    sw_q;
  result_t            sched_q[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // One input beat: record what the block shows before the tick, then step the state.
  task automatic advance_schedule(input flags_t f);
    logic               ending;
    logic               reuse_on;
    logic               trans_on;
    logic               conv_on;
    logic               wrap;
    logic               row_last;
    logic               bit_b;
    logic [COUNT_W-1:0] tgt;
    logic [PHASE_W-1:0] nph;
    logic [SW_W-1:0]    nsw;
    result_t            r;

    ending = (ph_q == PH_DOUT) &&
             (f.last_instruction ? f.register_file_clear
                                 : (f.update_finished | f.write_finished));
    reuse_on = cfg_q.reuse_mode != 2'd0;
    trans_on = cfg_q.transpose_mode != 2'd0;
    conv_on  = reuse_on && (sw_q[0] ^ sw_q[1]);
    if (reuse_on) begin
      tgt = {1'b0, cfg_q.flow_times};
    end else begin
      tgt = {cfg_q.flow_times, 1'b0};
      tgt = tgt - 7'd1;
    end
    wrap     = (flow_q == tgt) && f.load_done;
    row_last = row_q == ROWS - 1;

    r.phase          = ph_q;
    r.operand_switch = sw_q;
    r.flow_count     = flow_q;
    r.last_flow_mark = last_flow_q;
    r.flow_end       = ending;
    r.crossbar_done  = xbar_q;
    sched_q.push_back(r);

    case (ph_q)
      PH_REGLOAD: begin
        if (trans_on && f.load_done) nph = PH_TRANSLOAD;
        else if (conv_reuse_q && f.load_done) nph = PH_REUSELOAD;
        else nph = PH_REGLOAD;
      end
      PH_TRANSLOAD: nph = (row_last || f.load_done) ? PH_REUSELOAD : PH_TRANSLOAD;
      PH_FIRSTLOAD: begin
        if (f.execute_finished) nph = PH_DOUT;
        else nph = (conv_on && f.load_done) ? PH_REUSELOAD : PH_FIRSTLOAD;
      end
      PH_REUSELOAD: begin
        // a zero target never matches here: the tgt != 0 term rules it out
        if (f.execute_finished) nph = PH_DOUT;
        else if (tgt != 7'd0 && flow_q == tgt - 7'd1 && f.load_done && trans_on)
          nph = PH_FIRSTLOAD;
        else nph = PH_REUSELOAD;
      end
      PH_DOUT: nph = ending ? PH_IDLE : PH_DOUT;
      default: begin
        if (started_q && cfg_q.conv_kernel >= CONV_REG_MIN) nph = PH_REGLOAD;
        else nph = started_q ? PH_FIRSTLOAD : PH_IDLE;
      end
    endcase

    nsw = sw_q;
    case (ph_q)
      PH_FIRSTLOAD, PH_REGLOAD: begin
        if (ld_dly_q && !conv_on) nsw = {sw_q[1], ~sw_q[0]};
      end
      PH_TRANSLOAD: ;
      PH_REUSELOAD: begin
        if (conv_reuse_q) begin
          nsw = SW_REUSE;
        end else if (!(cfg_q.transpose_mode == TR_B_ONLY ||
                       cfg_q.transpose_mode == cfg_q.reuse_mode)) begin
          bit_b = ~cfg_q.transpose_mode[0];
          nsw = {bit_b, bit_b ^ last_flow_q};
        end
      end
      PH_DOUT: begin
        if (ending) nsw = SW_NONE;
      end
      default: begin
        nsw = (cfg_q.transpose_mode == TR_A_AND_B ||
               (cfg_q.transpose_mode == TR_B_ONLY && cfg_q.reuse_mode == REUSE_SPECIAL))
              ? SW_BOTH : SW_NONE;
      end
    endcase

    if (f.start_req) row_q = 0;
    else if (ph_q == PH_TRANSLOAD) row_q = row_last ? 0 : row_q + 1;

    if (f.start_req || wrap) flow_q = '0;
    else if (f.load_done) flow_q = flow_q + 7'd1;

    if (f.start_req || f.last_flow_clear) last_flow_q = 1'b0;
    else if (wrap) last_flow_q = 1'b1;

    started_q    = f.start_req;
    ld_dly_q     = f.load_done;
    conv_reuse_q = cfg_q.conv_kernel >= CONV_REG_MIN;
    xbar_q       = ending;
    ph_q         = nph;
    sw_q         = nsw;
  endtask

  task automatic check_result();
    result_t want;
    if (sched_q.size() == 0) begin
      report("result beat with nothing pending, phase", phase, 0);
      return;
    end
    want = sched_q.pop_front();
    if (phase !== want.phase) report("phase", phase, want.phase);
    if (operand_switch !== want.operand_switch)
      report("operand_switch", operand_switch, want.operand_switch);
    if (flow_count !== want.flow_count) report("flow_count", flow_count, want.flow_count);
    if (last_flow_mark !== want.last_flow_mark)
      report("last_flow_mark", last_flow_mark, want.last_flow_mark);
    if (flow_end !== want.flow_end) report("flow_end", flow_end, want.flow_end);
    if (crossbar_done !== want.crossbar_done)
      report("crossbar_done", crossbar_done, want.crossbar_done);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_q        = '0;
      ph_q         = PH_IDLE;
      started_q    = 1'b0;
      ld_dly_q     = 1'b0;
      conv_reuse_q = 1'b0;
      xbar_q       = 1'b0;
      last_flow_q  = 1'b0;
      flow_q       = '0;
      row_q        = 0;
      sw_q         = SW_NONE;
      sched_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REUSE_MODE:     cfg_q.reuse_mode = cfg_data[1:0];
          REG_TRANSPOSE_MODE: cfg_q.transpose_mode = cfg_data[1:0];
          REG_CONV_KERNEL:    cfg_q.conv_kernel = cfg_data[3:0];
          REG_FLOW_TIMES:     cfg_q.flow_times = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) advance_schedule(in_flags);
    end
    pending = sched_q.size();
  end

endmodule

@@ tb/tb_array_load_scheduler_fsm.sv @@
`timescale 1ns / 100ps

module tb_array_load_scheduler_fsm;
  import alsf_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  flags_t                flags = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic                  cfg_ready;
  logic [PHASE_W-1:0]    phase;
  logic [SW_W-1:0]       operand_switch;
  logic [COUNT_W-1:0]    flow_count;
  logic                  last_flow_mark;
  logic                  flow_end;
  logic                  crossbar_done;

  int   errors;
  int   pending;
  int   beats_sent = 0;
  logic calm = 1'b0;
  logic hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  array_load_scheduler_fsm dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .start_req           (flags.start_req),
    .load_done           (flags.load_done),
    .execute_finished    (flags.execute_finished),
    .last_instruction    (flags.last_instruction),
    .register_file_clear (flags.register_file_clear),
    .update_finished     (flags.update_finished),
    .write_finished      (flags.write_finished),
    .last_flow_clear     (flags.last_flow_clear),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .phase               (phase),
    .operand_switch      (operand_switch),
    .flow_count          (flow_count),
    .last_flow_mark      (last_flow_mark),
    .flow_end            (flow_end),
    .crossbar_done       (crossbar_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  alsf_sched_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_flags       (flags),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .phase          (phase),
    .operand_switch (operand_switch),
    .flow_count     (flow_count),
    .last_flow_mark (last_flow_mark),
    .flow_end       (flow_end),
    .crossbar_done  (crossbar_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending)
  );

  // receiver side: random stalls, none while calm, solid during the hold-off
  always @(negedge clk) begin
    out_stall <= hold_off || (!calm && $urandom_range(99) < 16);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (beats_sent >= 600);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic push_beat(input flags_t f);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    flags    <= f;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    logic [CFG_IDX_W-1:0]  regs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    regs = '{REG_REUSE_MODE, REG_TRANSPOSE_MODE, REG_CONV_KERNEL, REG_FLOW_TIMES};
    vals = '{6'(c.reuse_mode), 6'(c.transpose_mode), 6'(c.conv_kernel), c.flow_times};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // start, a run of loads, execute finished, then data out until it ends or eight beats pass
  task automatic run_instruction(input int n_load);
    flags_t f;
    logic   last_i;
    f = flags_t'(8'($urandom));
    f.start_req = 1'b1;
    f.execute_finished = 1'b0;
    push_beat(f);
    repeat (n_load) begin
      f = '0;
      f.load_done        = $urandom_range(99) < 45;
      f.last_flow_clear  = $urandom_range(99) < 6;
      f.update_finished  = 1'($urandom_range(1));
      f.last_instruction = 1'($urandom_range(1));
      push_beat(f);
    end
    f = '0;
    f.load_done = 1'($urandom_range(1));
    f.execute_finished = 1'b1;
    push_beat(f);
    last_i = 1'($urandom_range(1));
    for (int k = 0; k < 8; k++) begin
      f = '0;
      f.last_instruction    = last_i;
      f.register_file_clear = $urandom_range(99) < 30;
      f.update_finished     = $urandom_range(99) < 25;
      f.write_finished      = $urandom_range(99) < 25;
      f.load_done           = $urandom_range(99) < 20;
      push_beat(f);
      if (last_i ? f.register_file_clear : (f.update_finished | f.write_finished)) break;
    end
    repeat ($urandom_range(2)) push_beat('0);
  endtask

  task automatic random_phase(input int n);
    int stop;
    int n_load;
    stop = beats_sent + n;
    while (beats_sent < stop) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(10, 3)) push_beat(flags_t'(8'($urandom)));
      end else begin
        // now and then a long load run so the widest flow targets wrap
        n_load = ($urandom_range(99) < 6) ? $urandom_range(300, 150) : $urandom_range(12);
        run_instruction(n_load);
      end
    end
  endtask

  initial begin
    cfg_t plan[12];
    plan[0] = '{reuse_mode: 2'd0, transpose_mode: 2'd0, conv_kernel: 4'd0,  flow_times: 6'd0};
    plan[1] = '{reuse_mode: 2'd3, transpose_mode: 2'd2, conv_kernel: 4'd15, flow_times: 6'd63};
    plan[2] = '{reuse_mode: 2'd0, transpose_mode: 2'd2, conv_kernel: 4'd0,  flow_times: 6'd63};
    plan[3] = '{reuse_mode: 2'd1, transpose_mode: 2'd1, conv_kernel: 4'd3,  flow_times: 6'd1};
    plan[4] = '{reuse_mode: 2'd2, transpose_mode: 2'd1, conv_kernel: 4'd2,  flow_times: 6'd2};
    plan[5] = '{reuse_mode: 2'd2, transpose_mode: 2'd3, conv_kernel: 4'd4,  flow_times: 6'd0};
    plan[6] = '{reuse_mode: 2'd1, transpose_mode: 2'd0, conv_kernel: 4'd1,  flow_times: 6'd3};
    for (int i = 7; i < 12; i++) begin
      plan[i].reuse_mode     = 2'($urandom_range(3));
      plan[i].transpose_mode = 2'($urandom_range(3));
      plan[i].conv_kernel    = 4'($urandom_range(15));
      plan[i].flow_times     = ($urandom_range(3) == 0) ? 6'd63 : 6'($urandom_range(7));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: all clear, all set, each flag alone, two clean instructions
    load_config(plan[0]);
    push_beat('0);
    push_beat('1);
    for (int k = 0; k < 8; k++) push_beat(flags_t'(8'b1 << k));
    run_instruction(2);
    run_instruction(3);

    // a phase can end inside a long load run, so it overshoots its share
    for (int i = 0; i < 12; i++) begin
      if (i > 0) load_config(plan[i]);
      calm <= (i == 3);
      random_phase(80);
      drain();
    end
    calm <= 1'b0;

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
